// File: rtl/core/ucs_pkg.sv
// Types, constants and helpers shared by the UDP checksum stream unit.
package ucs_pkg;

  localparam logic [15:0] UDP_PROTOCOL = 16'd17;
  localparam logic [15:0] WORD_MASK    = 16'hFFFF;
  localparam int unsigned SUM_W        = 20;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last_item;
  } ucs_item_t;

  typedef struct packed {
    logic [15:0] running_sum;
    logic [7:0]  held_high_byte;
    logic        odd_pending;
    logic [15:0] byte_count;
    logic        count_saturated;
    logic        in_packet;
  } ucs_state_t;

  typedef struct packed {
    logic        emit;
    logic [15:0] checksum_value;
    logic        length_overflow;
  } ucs_result_t;

  // end-around carry fold of a wide sum down to 16 bits
  function automatic logic [15:0] ucs_fold(input logic [SUM_W-1:0] s);
    logic [16:0] f1;
    logic [16:0] f2;
    f1 = {1'b0, s[15:0]} + {13'd0, s[SUM_W-1:16]};
    f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
    return f2[15:0];
  endfunction

  function automatic logic [SUM_W-1:0] ucs_ext(input logic [15:0] w);
    return {{(SUM_W-16){1'b0}}, w};
  endfunction

endpackage

// File: rtl/core/ucs_byte_if.sv
// Input byte channel of the UDP checksum stream unit.
interface ucs_byte_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic        last_item;

  modport source (
    output valid, source_address, dest_address, data_byte, has_byte, last_item,
    input  ready
  );
  modport sink (
    input  valid, source_address, dest_address, data_byte, has_byte, last_item,
    output ready
  );
endinterface

// File: rtl/core/ucs_csum_if.sv
// Result channel of the UDP checksum stream unit.
interface ucs_csum_if;
  logic        valid;
  logic        ready;
  logic [15:0] checksum_value;
  logic        length_overflow;

  modport source (
    output valid, checksum_value, length_overflow,
    input  ready
  );
  modport sink (
    input  valid, checksum_value, length_overflow,
    output ready
  );
endinterface

// File: rtl/core/ucs_sum_core.sv
// Per-beat next-state and checksum logic of the UDP checksum stream unit.
module ucs_sum_core import ucs_pkg::*; (
  input  ucs_item_t   item_i,
  input  ucs_state_t  state_i,
  output ucs_state_t  state_o,
  output ucs_result_t result_o
);

  logic [SUM_W-1:0] pseudo_sum;
  logic [SUM_W-1:0] base_sum;
  logic [SUM_W-1:0] pair_word;
  logic [SUM_W-1:0] pad_word;
  logic [SUM_W-1:0] run_sum;
  logic [SUM_W-1:0] final_sum;
  logic [15:0]      base_count;
  logic             base_sat;
  logic             base_odd;
  logic [7:0]       base_held;
  logic [15:0]      count_nx;
  logic             sat_nx;
  logic             odd_nx;
  logic [7:0]       held_nx;
  logic             cnt_full;
  logic [15:0]      folded;
  logic [15:0]      csum;

  assign pseudo_sum = ucs_ext(item_i.source_address[31:16])
                    + ucs_ext(item_i.source_address[15:0])
                    + ucs_ext(item_i.dest_address[31:16])
                    + ucs_ext(item_i.dest_address[15:0])
                    + ucs_ext(UDP_PROTOCOL);

  // a byte or closing beat outside a packet opens one; an idle beat does not
  assign base_sum   = state_i.in_packet ? ucs_ext(state_i.running_sum) : pseudo_sum;
  assign base_count = state_i.in_packet ? state_i.byte_count : 16'd0;
  assign base_sat   = state_i.in_packet & state_i.count_saturated;
  assign base_odd   = state_i.in_packet & state_i.odd_pending;
  assign base_held  = state_i.in_packet ? state_i.held_high_byte : 8'd0;

  assign cnt_full = (base_count == WORD_MASK);

  always_comb begin
    count_nx  = base_count;
    sat_nx    = base_sat;
    odd_nx    = base_odd;
    held_nx   = base_held;
    pair_word = '0;
    if (item_i.has_byte) begin
      if (base_odd) begin
        pair_word = ucs_ext({base_held, item_i.data_byte});
        odd_nx    = 1'b0;
        held_nx   = 8'd0;
      end else begin
        held_nx = item_i.data_byte;
        odd_nx  = 1'b1;
      end
      if (cnt_full) begin
        sat_nx = 1'b1;
      end else begin
        count_nx = base_count + 16'd1;
      end
    end
  end

  assign pad_word  = odd_nx ? ucs_ext({held_nx, 8'd0}) : '0;
  assign run_sum   = base_sum + pair_word;
  assign final_sum = run_sum + pad_word + ucs_ext(count_nx);
  assign folded    = ucs_fold(final_sum);
  assign csum      = ~folded;

  always_comb begin
    if (!item_i.has_byte && !item_i.last_item) begin
      state_o = state_i;
    end else if (item_i.last_item) begin
      state_o = '0;
    end else begin
      state_o.running_sum     = ucs_fold(run_sum);
      state_o.held_high_byte  = held_nx;
      state_o.odd_pending     = odd_nx;
      state_o.byte_count      = count_nx;
      state_o.count_saturated = sat_nx;
      state_o.in_packet       = 1'b1;
    end
  end

  assign result_o.emit            = item_i.last_item;
  assign result_o.checksum_value  = (csum == 16'd0) ? WORD_MASK : csum;
  assign result_o.length_overflow = sat_nx;

endmodule

// File: rtl/core/udp_checksum_stream_unit.sv
// UDP checksum stream unit: one byte per beat, checksum on the closing beat.
// A closing beat's result is loaded into the result register as the beat leaves the input register.
// Throughput: one beat per cycle; the input register and the result register
// decouple the two sides, only a full result register holds a closing beat.
// Reset (rst_ni low, async) clears packet state and both valid flags.
module udp_checksum_stream_unit import ucs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  ucs_byte_if.sink   in_i,
  ucs_csum_if.source out_o
);

  logic        s1_valid_q;
  ucs_item_t   s1_item_q;
  ucs_state_t  state_q;
  ucs_state_t  state_d;
  ucs_result_t res;
  logic        out_valid_q;
  logic [15:0] out_csum_q;
  logic        out_ovf_q;
  logic        out_space;
  logic        advance;
  logic        in_take;

  ucs_sum_core u_core (
    .item_i   (s1_item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res)
  );

  assign out_space = !out_valid_q || out_o.ready;
  assign advance   = s1_valid_q && (!res.emit || out_space);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_take   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q.source_address <= in_i.source_address;
      s1_item_q.dest_address   <= in_i.dest_address;
      s1_item_q.data_byte      <= in_i.data_byte;
      s1_item_q.has_byte       <= in_i.has_byte;
      s1_item_q.last_item      <= in_i.last_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_space) begin
      out_valid_q <= advance && res.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.emit) begin
      out_csum_q <= res.checksum_value;
      out_ovf_q  <= res.length_overflow;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.checksum_value  = out_csum_q;
  assign out_o.length_overflow = out_ovf_q;

`ifndef SYNTH
  a_idle_state_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.in_packet |-> (!state_q.odd_pending && state_q.byte_count == 16'd0
                            && !state_q.count_saturated))
    else $error("packet state not cleared outside a packet");

  a_odd_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.in_packet && !state_q.count_saturated)
      |-> (state_q.odd_pending == state_q.byte_count[0]))
    else $error("odd byte flag out of step with byte count");

  a_no_zero_csum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_csum_q != 16'd0))
    else $error("zero checksum emitted");

  a_close_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.emit) |=> out_valid_q)
    else $error("closing beat produced no result");
`endif

endmodule

// File: verif/tb_udp_checksum_stream_unit.sv
`timescale 1ns / 100ps
// Testbench of udp_checksum_stream_unit: byte beats in, a predicted checksum per packet compared out.
module tb_udp_checksum_stream_unit;
  import ucs_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [15:0] checksum;
    logic        overflow;
  } csum_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ucs_byte_if byte_bus ();
  ucs_csum_if csum_bus ();

  udp_checksum_stream_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_bus),
    .out_o (csum_bus)
  );

  logic [15:0] sum_acc;
  logic [7:0]  high_byte;
  logic        byte_odd;
  logic [15:0] seg_bytes;
  logic        seg_sat;
  logic        seg_open;
  csum_t       csum_q[$];

  int unsigned mismatch_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned beats_counted;
  int unsigned stall_cycles = 0;

  always #5 clk_i = ~clk_i;

  function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic void predict_checksum(ucs_item_t it);
    logic [15:0] result;
    if (!it.has_byte && !it.last_item) return;
    if (!seg_open) begin
      sum_acc   = ones_add(16'd0, it.source_address[31:16]);
      sum_acc   = ones_add(sum_acc, it.source_address[15:0]);
      sum_acc   = ones_add(sum_acc, it.dest_address[31:16]);
      sum_acc   = ones_add(sum_acc, it.dest_address[15:0]);
      sum_acc   = ones_add(sum_acc, UDP_PROTOCOL);
      high_byte = 8'h00;
      byte_odd  = 1'b0;
      seg_bytes = 16'd0;
      seg_sat   = 1'b0;
      seg_open  = 1'b1;
    end
    if (it.has_byte) begin
      if (byte_odd) begin
        sum_acc  = ones_add(sum_acc, {high_byte, it.data_byte});
        byte_odd = 1'b0;
      end else begin
        high_byte = it.data_byte;
        byte_odd  = 1'b1;
      end
      if (seg_bytes == WORD_MASK) begin
        seg_sat = 1'b1;
      end else begin
        seg_bytes = seg_bytes + 16'd1;
      end
    end
    if (it.last_item) begin
      if (byte_odd) begin
        sum_acc = ones_add(sum_acc, {high_byte, 8'h00});
      end
      sum_acc = ones_add(sum_acc, seg_bytes);
      result  = ~sum_acc;
      if (result == 16'h0000) begin
        result = WORD_MASK;
      end
      csum_q.push_back(csum_t'{checksum: result, overflow: seg_sat});
      seg_open = 1'b0;
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_cnt++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic ucs_item_t idle_item();
    ucs_item_t it;
    it.source_address = $urandom();
    it.dest_address   = $urandom();
    it.data_byte      = 8'($urandom());
    it.has_byte       = 1'b0;
    it.last_item      = 1'b0;
    return it;
  endfunction

  task automatic send_beat(ucs_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_bus.valid          <= 1'b1;
    byte_bus.source_address <= it.source_address;
    byte_bus.dest_address   <= it.dest_address;
    byte_bus.data_byte      <= it.data_byte;
    byte_bus.has_byte       <= it.has_byte;
    byte_bus.last_item      <= it.last_item;
    do @(posedge clk_i); while (byte_bus.ready !== 1'b1);
    predict_checksum(it);
    if (it.has_byte || it.last_item) beats_counted++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    byte_bus.valid <= 1'b0;
    while (csum_q.size() != 0) @(posedge clk_i);
  endtask

  // later beats carry random addresses; only the first beat's must count
  task automatic send_packet(logic [31:0] src, logic [31:0] dst, int unsigned len,
                             bit close_alone, int unsigned gap_pct);
    ucs_item_t it;
    for (int unsigned i = 0; i < len; i++) begin
      while ($urandom_range(99) < gap_pct) send_beat(idle_item());
      it.source_address = (i == 0) ? src : $urandom();
      it.dest_address   = (i == 0) ? dst : $urandom();
      it.data_byte      = pick_byte();
      it.has_byte       = 1'b1;
      it.last_item      = (i == len - 1) && !close_alone;
      send_beat(it);
    end
    if (len == 0 || close_alone) begin
      it.source_address = (len == 0) ? src : $urandom();
      it.dest_address   = (len == 0) ? dst : $urandom();
      it.data_byte      = 8'($urandom());
      it.has_byte       = 1'b0;
      it.last_item      = 1'b1;
      send_beat(it);
    end
  endtask

  task automatic test_idle_beats();
    send_beat(idle_item());
    send_beat(idle_item());
    send_packet(32'h0000_0000, 32'h0000_0000, 0, 1'b0, 0);
  endtask

  task automatic test_empty_packets();
    send_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0, 0);
    send_packet(32'h1234_5678, 32'h9ABC_DEF0, 0, 1'b0, 0);
  endtask

  task automatic test_zero_checksum();
    send_packet(32'h0000_FFEE, 32'h0000_0000, 0, 1'b0, 0);
    send_beat(ucs_item_t'{source_address: 32'h0, dest_address: 32'h0,
                          data_byte: 8'hFF, has_byte: 1'b1, last_item: 1'b0});
    send_beat(ucs_item_t'{source_address: 32'hFFFF_FFFF, dest_address: 32'hFFFF_FFFF,
                          data_byte: 8'hEC, has_byte: 1'b1, last_item: 1'b1});
  endtask

  task automatic test_byte_extremes();
    send_beat(ucs_item_t'{source_address: 32'hC0A8_0001, dest_address: 32'h0A00_0001,
                          data_byte: 8'hFF, has_byte: 1'b1, last_item: 1'b0});
    send_beat(ucs_item_t'{source_address: 32'h0, dest_address: 32'h0,
                          data_byte: 8'hFF, has_byte: 1'b1, last_item: 1'b0});
    send_beat(ucs_item_t'{source_address: 32'h0, dest_address: 32'h0,
                          data_byte: 8'hFF, has_byte: 1'b1, last_item: 1'b1});
    send_beat(ucs_item_t'{source_address: 32'hFFFF_0000, dest_address: 32'h0000_FFFF,
                          data_byte: 8'h00, has_byte: 1'b1, last_item: 1'b0});
    send_beat(ucs_item_t'{source_address: 32'hFFFF_FFFF, dest_address: 32'hFFFF_FFFF,
                          data_byte: 8'h00, has_byte: 1'b1, last_item: 1'b0});
    send_beat(ucs_item_t'{source_address: 32'h0, dest_address: 32'h0,
                          data_byte: 8'h00, has_byte: 1'b0, last_item: 1'b1});
    send_beat(ucs_item_t'{source_address: 32'h8000_0001, dest_address: 32'h7FFF_FFFE,
                          data_byte: 8'h80, has_byte: 1'b1, last_item: 1'b1});
  endtask

  task automatic test_address_latch();
    send_packet(32'hDEAD_BEEF, 32'h0123_4567, 6, 1'b1, 40);
    send_packet(32'h5555_AAAA, 32'hAAAA_5555, 5, 1'b0, 40);
  endtask

  task automatic test_result_drain();
    send_packet($urandom(), $urandom(), 7, 1'b0, 0);
    wait_drained();
    send_packet($urandom(), $urandom(), 4, 1'b1, 0);
  endtask

  task automatic test_random_packets(int unsigned target);
    int unsigned base_count;
    int unsigned len;
    base_count = beats_counted;
    while (beats_counted - base_count < target) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(120, 17) : $urandom_range(16);
      send_packet($urandom(), $urandom(), len, $urandom_range(3) == 0, 8);
      if ($urandom_range(9) == 0) send_beat(idle_item());
    end
  endtask

  initial begin
    csum_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      csum_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : csum_check
    csum_t want;
    if (rst_ni && csum_bus.valid === 1'b1 && csum_bus.ready === 1'b1) begin
      if (csum_q.size() == 0) begin
        report_mismatch($sformatf("unexpected checksum %h", csum_bus.checksum_value));
      end else begin
        want = csum_q.pop_front();
        if (csum_bus.checksum_value !== want.checksum) begin
          report_mismatch($sformatf("checksum_value %h, want %h",
                                    csum_bus.checksum_value, want.checksum));
        end
        if (csum_bus.length_overflow !== want.overflow) begin
          report_mismatch($sformatf("length_overflow %b, want %b",
                                    csum_bus.length_overflow, want.overflow));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((byte_bus.valid === 1'b1 && byte_bus.ready === 1'b1) ||
        (csum_bus.valid === 1'b1 && csum_bus.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    byte_bus.valid          = 1'b0;
    byte_bus.source_address = '0;
    byte_bus.dest_address   = '0;
    byte_bus.data_byte      = '0;
    byte_bus.has_byte       = 1'b0;
    byte_bus.last_item      = 1'b0;
    sum_acc       = '0;
    high_byte     = '0;
    byte_odd      = 1'b0;
    seg_bytes     = '0;
    seg_sat       = 1'b0;
    seg_open      = 1'b0;
    mismatch_cnt  = 0;
    beats_counted = 0;
    send_idle_pct = 10;
    recv_idle_pct = 66;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_idle_beats();
    test_empty_packets();
    test_zero_checksum();
    test_byte_extremes();
    test_address_latch();
    test_result_drain();
    test_random_packets(150);

    send_idle_pct = 66;
    recv_idle_pct = 10;
    test_random_packets(170);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_packets(160);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
